// ----- rtl/double_ended_queue_assert.svh -----
// Assertion macros of the queue RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Plain property, checked at every rising edge outside reset
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
// Shared types and constants of the double-ended queue.
// No dependencies; compiled first.
package deq_pkg;

	localparam int unsigned DEPTH_DEF  = 64;
	localparam int unsigned DATA_W_DEF = 32;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FILL_W   = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_LIST       = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 3'd0,
		ST_POP_EMPTY  = 3'd1,
		ST_PUSH_FULL  = 3'd2,
		ST_LISTED     = 3'd3,
		ST_LIST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] elem_value;
		status_t                   status;
		logic                      last_of_run;
		logic [FILL_W-1:0]         fill_count;
	} res_t;

endpackage

// ----- rtl/deq_ifs.sv -----
// Request and result channel interfaces of the double-ended queue.
// Depends on deq_pkg for the field widths.
interface deq_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [deq_pkg::ACTION_W-1:0]       action;
	logic signed [deq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [deq_pkg::VALUE_W-1:0] elem_value;
	logic [deq_pkg::STATUS_W-1:0]       status;
	logic                               last_of_run;
	logic [deq_pkg::FILL_W-1:0]         fill_count;

	modport source (output valid, output elem_value, output status, output last_of_run,
		output fill_count, input ready);
	modport sink   (input valid, input elem_value, input status, input last_of_run,
		input fill_count, output ready);
endinterface

// ----- rtl/deq_store.sv -----
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module deq_store #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/deq_outbuf.sv -----
// Two-entry result buffer that drives the result channel.
// Depends on deq_pkg (res_t) and deq_ifs (deq_rsp_if).
module deq_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  deq_pkg::res_t wdata,
	output logic [1:0]    lvl,
	deq_rsp_if.source     rsp
);
	import deq_pkg::*;

	res_t ent_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] lvl_q;
	logic pop;

	assign pop = rsp.valid && rsp.ready;
	assign lvl = lvl_q;

	assign rsp.valid       = (lvl_q != 2'd0);
	assign rsp.elem_value  = ent_q[rp_q].elem_value;
	assign rsp.status      = ent_q[rp_q].status;
	assign rsp.last_of_run = ent_q[rp_q].last_of_run;
	assign rsp.fill_count  = ent_q[rp_q].fill_count;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			lvl_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			// hold the level when both or neither happen
			if (wr && !pop) begin
				lvl_q <= lvl_q + 2'd1;
			end else if (pop && !wr) begin
				lvl_q <= lvl_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue of DEPTH signed values kept in a ring in one synchronous memory.
// Each request pushes at the front or back, pops at either end or lists the contents,
// and gives one result; a listing gives one result per stored element, front to back,
// the last one marked, or a single list-empty result. A push into a full queue is dropped
// and flagged, a pop on an empty queue is ignored and flagged. Push, pop and unused codes
// may follow back to back while the result buffer has room. A listing holds off the next
// request until its last element is read and passed on: the memory has a single read port,
// so elements come out one per cycle while results have room. Results pass through
// a two-entry buffer, so the request side keeps moving while a result waits to be taken.
// Depends on deq_pkg, deq_ifs, deq_store, deq_outbuf and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = deq_pkg::DATA_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_cmd_if.sink   cmd,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0] remain_q, remain_d;
	logic rd_s1, rd_last_s1;

	logic acc, pop_out, room, full, empty;
	logic [1:0] lvl;
	logic [2:0] occ;
	logic [IDX_W-1:0] front_dec, front_inc, slot_inc, back_slot;
	logic [CNT_W:0] back_sum;
	logic we, issue, last_iss, wr_res;
	logic [IDX_W-1:0] waddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [63:0] val_ext, rd_ext;
	res_t res;

	assign pop_out = rsp.valid && rsp.ready;
	// occupancy of the result buffer including a read in flight
	assign occ  = {1'b0, lvl} + {2'b00, rd_s1};
	assign room = (occ < (3'd2 + {2'b00, pop_out}));

	assign cmd.ready = (state_q == S_IDLE) && !rd_s1 && room;
	assign acc       = cmd.valid && cmd.ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign slot_inc  = (slot_q == IDX_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign back_sum  = {{(CNT_W+1-IDX_W){1'b0}}, front_q} + {1'b0, count_q};
	assign back_slot = (back_sum >= (CNT_W+1)'(DEPTH)) ?
		IDX_W'(back_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(back_sum);

	assign val_ext = {32'b0, cmd.value};
	assign wdata   = val_ext[DATA_WIDTH-1:0];
	assign rd_ext  = 64'(rdata);

	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		count_d  = count_q;
		slot_d   = slot_q;
		remain_d = remain_q;
		we       = 1'b0;
		waddr    = front_dec;
		issue    = 1'b0;
		last_iss = 1'b0;
		wr_res   = 1'b0;
		res.elem_value  = '0;
		res.status      = ST_DONE;
		res.last_of_run = 1'b1;
		res.fill_count  = FILL_W'(count_q);

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					wr_res = 1'b1;
					unique case (cmd.action)
						ACT_PUSH_FRONT: begin
							if (full) begin
								res.status = ST_PUSH_FULL;
							end else begin
								we      = 1'b1;
								waddr   = front_dec;
								front_d = front_dec;
								count_d = count_q + 1'b1;
							end
						end
						ACT_PUSH_BACK: begin
							if (full) begin
								res.status = ST_PUSH_FULL;
							end else begin
								we      = 1'b1;
								waddr   = back_slot;
								count_d = count_q + 1'b1;
							end
						end
						ACT_POP_FRONT: begin
							if (empty) begin
								res.status = ST_POP_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - 1'b1;
							end
						end
						ACT_POP_BACK: begin
							if (empty) begin
								res.status = ST_POP_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						ACT_LIST: begin
							if (empty) begin
								res.status = ST_LIST_EMPTY;
							end else begin
								// results come from the read sweep instead
								wr_res   = 1'b0;
								state_d  = S_LIST;
								slot_d   = front_q;
								remain_d = count_q;
							end
						end
						default: begin
						end
					endcase
					res.fill_count = FILL_W'(count_d);
				end
			end
			S_LIST: begin
				// issue one read per cycle while the buffer can take its data
				if (room) begin
					issue    = 1'b1;
					last_iss = (remain_q == CNT_W'(1));
					slot_d   = slot_inc;
					remain_d = remain_q - 1'b1;
					if (last_iss) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (rd_s1) begin
			wr_res          = 1'b1;
			res.elem_value  = rd_ext[VALUE_W-1:0];
			res.status      = ST_LISTED;
			res.last_of_run = rd_last_s1;
			res.fill_count  = FILL_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			rd_s1      <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			rd_s1      <= issue;
			rd_last_s1 <= last_iss;
		end
	end

	always_ff @(posedge clk) begin
		slot_q   <= slot_d;
		remain_q <= remain_d;
	end

	// a write always comes before any read of the same entry, never in the same cycle
	deq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (slot_q),
		.rdata (rdata)
	);

	deq_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr_res),
		.wdata  (res),
		.lvl    (lvl),
		.rsp    (rsp)
	);

	`DEQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`DEQ_ASSERT_IMP(a_no_clash, clk, arst_n, rd_s1, !acc, "request taken with read in flight")
	`DEQ_ASSERT_IMP(a_buf_room, clk, arst_n, wr_res && !pop_out, lvl != 2'd2, "result buffer overrun")
	`DEQ_ASSERT_IMP(a_last_idle, clk, arst_n, rd_s1 && rd_last_s1, state_q == S_IDLE, "last read but still listing")
	`DEQ_ASSERT_NXT(a_list_hold, clk, arst_n, issue && !last_iss, state_q == S_LIST && count_q == $past(count_q), "listing ended early")

endmodule
